[hdl/cscan_disk_request_scheduler_core_defines.svh]
// ----------------------------------------------------------------------------
// C-SCAN disk request scheduler: assertion macros
// Shared macros for the concurrent checks on the scheduler ports.
// ----------------------------------------------------------------------------
`ifndef CSCAN_DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH
`define CSCAN_DISK_REQUEST_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while reset is asserted.
`define CDRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is asserted.
`define CDRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cdrs_pkg.sv]
// ----------------------------------------------------------------------------
// C-SCAN disk request scheduler package
// Command and status codes and the control bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package cdrs_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;

    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_QUEUED    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_HANDED    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_IDLE      = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_CANCELLED = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND  = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the accepted request and restart the sweep
        logic issue;   // read the waiter entry at the sweep index
        logic commit;  // apply the outcome and load the result register
    } cdrs_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;  // sweep index is at the last entry
        logic out_free;   // result register can take a new result
    } cdrs_sts_t;

endpackage

[hdl/cdrs_datapath.sv]
// ----------------------------------------------------------------------------
// C-SCAN scheduler datapath
// Waiter table, sweep pipeline, lowest-track search and result register.
// ----------------------------------------------------------------------------
module cdrs_datapath #(
    parameter int MAX_WAITERS = 16,
    parameter int TRACK_BITS  = 16,
    parameter int ID_BITS     = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cdrs_pkg::cdrs_ctl_t           ctl,
    output cdrs_pkg::cdrs_sts_t           sts,
    input  logic [cdrs_pkg::CMD_W-1:0]    in_cmd,
    input  logic [ID_BITS-1:0]            in_requester,
    input  logic [TRACK_BITS-1:0]         in_track,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [cdrs_pkg::STATUS_W-1:0] out_status,
    output logic                          out_grant_valid,
    output logic [ID_BITS-1:0]            out_grant_requester,
    output logic [TRACK_BITS-1:0]         out_grant_track,
    output logic                          out_disk_busy
);
    import cdrs_pkg::*;

    localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int AGE_W = IDX_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAITERS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_WAITERS - 1);

    // Waiter table payload, written and read at one address each.
    logic [ID_BITS-1:0]    req_mem  [MAX_WAITERS];
    logic [TRACK_BITS-1:0] trk_mem  [MAX_WAITERS];
    logic                  side_mem [MAX_WAITERS];
    logic [AGE_W-1:0]      age_mem  [MAX_WAITERS];

    logic [MAX_WAITERS-1:0] valid_reg, valid_next;
    logic                   ahead_reg, ahead_next;
    logic [TRACK_BITS-1:0]  head_reg, head_next;
    logic                   busy_reg, busy_next;

    logic [CMD_W-1:0]      cmd_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [TRACK_BITS-1:0] trk_reg;

    logic [IDX_W-1:0]      scan_idx_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic [ID_BITS-1:0]    rd_req_reg;
    logic [TRACK_BITS-1:0] rd_trk_reg;
    logic                  rd_side_reg;
    logic [AGE_W-1:0]      rd_age_reg;

    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             hit_reg, hit_next;

    // Best candidate on the ahead side (a) and on the behind side (b).
    logic                  ba_found_reg, ba_found_next, bb_found_reg, bb_found_next;
    logic [IDX_W-1:0]      ba_idx_reg, ba_idx_next, bb_idx_reg, bb_idx_next;
    logic [TRACK_BITS-1:0] ba_trk_reg, ba_trk_next, bb_trk_reg, bb_trk_next;
    logic [AGE_W-1:0]      ba_age_reg, ba_age_next, bb_age_reg, bb_age_next;
    logic [ID_BITS-1:0]    ba_req_reg, ba_req_next, bb_req_reg, bb_req_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                  out_gv_reg, out_gv_next;
    logic [ID_BITS-1:0]    out_greq_reg, out_greq_next;
    logic [TRACK_BITS-1:0] out_gtrk_reg, out_gtrk_next;

    logic                  is_req, is_rel, is_can;
    logic                  cur_valid;
    logic                  tbl_full;
    logic                  age_we;
    logic [IDX_W-1:0]      age_waddr;
    logic [AGE_W-1:0]      age_wdata;
    logic                  ins_we;
    logic                  ins_side;
    logic                  better_a, better_b;

    assign is_req    = (cmd_reg == CMD_REQUEST);
    assign is_rel    = (cmd_reg == CMD_RELEASE);
    assign is_can    = (cmd_reg == CMD_CANCEL);
    assign cur_valid = valid_reg[rd_idx_reg];
    // A request sweep never changes the valid bits, so this holds for the whole sweep.
    assign tbl_full  = &valid_reg;

    assign sts.scan_last = (scan_idx_reg == IDX_LAST);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign better_a = !ba_found_reg || (rd_trk_reg < ba_trk_reg) ||
                      ((rd_trk_reg == ba_trk_reg) && (rd_age_reg > ba_age_reg));
    assign better_b = !bb_found_reg || (rd_trk_reg < bb_trk_reg) ||
                      ((rd_trk_reg == bb_trk_reg) && (rd_age_reg > bb_age_reg));

    assign ins_we   = ctl.commit && is_req && busy_reg && free_found_reg;
    assign ins_side = (trk_reg >= head_reg) ? ahead_reg : !ahead_reg;

    // Age port: sweep increments on a queued request, zero for a new waiter.
    // A request that meets a full table is rejected and ages nobody.
    always_comb begin
        age_we    = 1'b0;
        age_waddr = rd_idx_reg;
        age_wdata = rd_age_reg + AGE_W'(1);
        if (ins_we) begin
            age_we    = 1'b1;
            age_waddr = free_idx_reg;
            age_wdata = '0;
        end else if (rd_vld_reg && is_req && busy_reg && !tbl_full && cur_valid &&
                     (rd_age_reg < AGE_MAX)) begin
            age_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.issue) begin
            rd_req_reg  <= req_mem[scan_idx_reg];
            rd_trk_reg  <= trk_mem[scan_idx_reg];
            rd_side_reg <= side_mem[scan_idx_reg];
            rd_age_reg  <= age_mem[scan_idx_reg];
        end
        if (ins_we) begin
            req_mem[free_idx_reg]  <= id_reg;
            trk_mem[free_idx_reg]  <= trk_reg;
            side_mem[free_idx_reg] <= ins_side;
        end
        if (age_we) begin
            age_mem[age_waddr] <= age_wdata;
        end
    end

    always_comb begin
        valid_next      = valid_reg;
        ahead_next      = ahead_reg;
        head_next       = head_reg;
        busy_next       = busy_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_next        = hit_reg;
        ba_found_next   = ba_found_reg;
        ba_idx_next     = ba_idx_reg;
        ba_trk_next     = ba_trk_reg;
        ba_age_next     = ba_age_reg;
        ba_req_next     = ba_req_reg;
        bb_found_next   = bb_found_reg;
        bb_idx_next     = bb_idx_reg;
        bb_trk_next     = bb_trk_reg;
        bb_age_next     = bb_age_reg;
        bb_req_next     = bb_req_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_gv_next     = out_gv_reg;
        out_greq_next   = out_greq_reg;
        out_gtrk_next   = out_gtrk_reg;

        if (ctl.load) begin
            free_found_next = 1'b0;
            hit_next        = 1'b0;
            ba_found_next   = 1'b0;
            bb_found_next   = 1'b0;
        end

        // One table entry is examined per cycle as the sweep data returns.
        if (rd_vld_reg) begin
            if (!cur_valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = rd_idx_reg;
            end
            if (cur_valid && is_can && (rd_req_reg == id_reg)) begin
                valid_next[rd_idx_reg] = 1'b0;
                hit_next               = 1'b1;
            end
            if (cur_valid && (rd_side_reg == ahead_reg) && better_a) begin
                ba_found_next = 1'b1;
                ba_idx_next   = rd_idx_reg;
                ba_trk_next   = rd_trk_reg;
                ba_age_next   = rd_age_reg;
                ba_req_next   = rd_req_reg;
            end
            if (cur_valid && (rd_side_reg != ahead_reg) && better_b) begin
                bb_found_next = 1'b1;
                bb_idx_next   = rd_idx_reg;
                bb_trk_next   = rd_trk_reg;
                bb_age_next   = rd_age_reg;
                bb_req_next   = rd_req_reg;
            end
        end

        if (ctl.commit) begin
            out_valid_next  = 1'b1;
            out_status_next = STATUS_NOTFOUND;
            out_gv_next     = 1'b0;
            out_greq_next   = '0;
            out_gtrk_next   = '0;
            priority if (is_req) begin
                if (!busy_reg) begin
                    busy_next       = 1'b1;
                    head_next       = trk_reg;
                    out_status_next = STATUS_GRANTED;
                    out_gv_next     = 1'b1;
                    out_greq_next   = id_reg;
                    out_gtrk_next   = trk_reg;
                end else if (free_found_reg) begin
                    valid_next[free_idx_reg] = 1'b1;
                    out_status_next          = STATUS_QUEUED;
                end else begin
                    out_status_next = STATUS_FULL;
                end
            end else if (is_rel) begin
                if (ba_found_reg) begin
                    valid_next[ba_idx_reg] = 1'b0;
                    head_next              = ba_trk_reg;
                    busy_next              = 1'b1;
                    out_status_next        = STATUS_HANDED;
                    out_gv_next            = 1'b1;
                    out_greq_next          = ba_req_reg;
                    out_gtrk_next          = ba_trk_reg;
                end else if (bb_found_reg) begin
                    // Ahead side is empty: the sides swap.
                    valid_next[bb_idx_reg] = 1'b0;
                    ahead_next             = !ahead_reg;
                    head_next              = bb_trk_reg;
                    busy_next              = 1'b1;
                    out_status_next        = STATUS_HANDED;
                    out_gv_next            = 1'b1;
                    out_greq_next          = bb_req_reg;
                    out_gtrk_next          = bb_trk_reg;
                end else begin
                    busy_next       = 1'b0;
                    out_status_next = STATUS_IDLE;
                end
            end else if (is_can) begin
                out_status_next = hit_reg ? STATUS_CANCELLED : STATUS_NOTFOUND;
            end else begin
                out_status_next = STATUS_NOTFOUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            ahead_reg     <= 1'b0;
            head_reg      <= '0;
            busy_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            ahead_reg     <= ahead_next;
            head_reg      <= head_next;
            busy_reg      <= busy_next;
            rd_vld_reg    <= ctl.issue;
            out_valid_reg <= out_valid_next;
            if (ctl.load) begin
                scan_idx_reg <= '0;
            end else if (ctl.issue) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg <= in_cmd;
            id_reg  <= in_requester;
            trk_reg <= in_track;
        end
        rd_idx_reg     <= scan_idx_reg;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        hit_reg        <= hit_next;
        ba_found_reg   <= ba_found_next;
        ba_idx_reg     <= ba_idx_next;
        ba_trk_reg     <= ba_trk_next;
        ba_age_reg     <= ba_age_next;
        ba_req_reg     <= ba_req_next;
        bb_found_reg   <= bb_found_next;
        bb_idx_reg     <= bb_idx_next;
        bb_trk_reg     <= bb_trk_next;
        bb_age_reg     <= bb_age_next;
        bb_req_reg     <= bb_req_next;
        out_status_reg <= out_status_next;
        out_gv_reg     <= out_gv_next;
        out_greq_reg   <= out_greq_next;
        out_gtrk_reg   <= out_gtrk_next;
    end

    assign out_valid           = out_valid_reg;
    assign out_status          = out_status_reg;
    assign out_grant_valid     = out_gv_reg;
    assign out_grant_requester = out_greq_reg;
    assign out_grant_track     = out_gtrk_reg;
    assign out_disk_busy       = busy_reg;

endmodule

[hdl/cdrs_ctrl.sv]
// ----------------------------------------------------------------------------
// C-SCAN scheduler controller
// Sequences accept, table sweep, pipeline drain and commit for each request.
// ----------------------------------------------------------------------------
module cdrs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  cdrs_pkg::cdrs_sts_t sts,
    output cdrs_pkg::cdrs_ctl_t ctl
);
    import cdrs_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_TAIL   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                ctl.issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (sts.out_free) begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/cscan_disk_request_scheduler_core.sv]
// Each accepted request sweeps the waiter table, drains the read pipeline and commits
// its result to m_tvalid once the result register is free; no new request is taken
// before that commit. The sweep uses the single table read port, one entry per cycle.
// A finished result waits in the output register while the next request is taken.
// Reset (aresetn low, synchronous) empties the table, frees the disk, puts the head
// at track zero and selects side zero as the ahead side; no clearing pass is needed.
// ----------------------------------------------------------------------------
// C-SCAN disk request scheduler top level
// One-direction elevator arbiter for a single disk head with a waiter table.
// ----------------------------------------------------------------------------
module cscan_disk_request_scheduler_core #(
    parameter int  MAX_WAITERS = 16,
    parameter int  TRACK_BITS  = 16,
    parameter int  ID_BITS     = 4,
    localparam int S_DATA_W    = ((2 + ID_BITS + TRACK_BITS + 7) / 8) * 8,
    localparam int M_DATA_W    = ((5 + ID_BITS + TRACK_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Request channel.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // cmd, requester, track (from bit 0 up)
    // Result channel.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status, grant_valid, grant_requester,
                                           // grant_track, disk_busy (from bit 0 up)
);
    import cdrs_pkg::*;

    // Each request runs a full sweep over the waiter table. The sweep ages the
    // waiters and finds the first free entry for a queued request, tracks the
    // lowest track on each side (oldest first on a tie) for a release, and
    // drops matching waiters for a cancel. The outcome is applied in one
    // commit cycle once the result register is free.

    logic [CMD_W-1:0]      in_cmd;
    logic [ID_BITS-1:0]    in_requester;
    logic [TRACK_BITS-1:0] in_track;

    logic [STATUS_W-1:0]   out_status;
    logic                  out_grant_valid;
    logic [ID_BITS-1:0]    out_grant_requester;
    logic [TRACK_BITS-1:0] out_grant_track;
    logic                  out_disk_busy;

    cdrs_ctl_t ctl;
    cdrs_sts_t sts;

    assign in_cmd       = s_tdata[CMD_W-1:0];
    assign in_requester = s_tdata[CMD_W +: ID_BITS];
    assign in_track     = s_tdata[CMD_W + ID_BITS +: TRACK_BITS];

    cdrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    cdrs_datapath #(
        .MAX_WAITERS (MAX_WAITERS),
        .TRACK_BITS  (TRACK_BITS),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .ctl                 (ctl),
        .sts                 (sts),
        .in_cmd              (in_cmd),
        .in_requester        (in_requester),
        .in_track            (in_track),
        .out_ready           (m_tready),
        .out_valid           (m_tvalid),
        .out_status          (out_status),
        .out_grant_valid     (out_grant_valid),
        .out_grant_requester (out_grant_requester),
        .out_grant_track     (out_grant_track),
        .out_disk_busy       (out_disk_busy)
    );

    // Fields packed from bit 0 up and zero-filled to whole bytes.
    assign m_tdata = M_DATA_W'({out_disk_busy, out_grant_track, out_grant_requester,
                                out_grant_valid, out_status});

endmodule

[hdl/cdrs_checker.sv]
// ----------------------------------------------------------------------------
// C-SCAN scheduler port checker
// Concurrent checks on the scheduler ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "cscan_disk_request_scheduler_core_defines.svh"

module cdrs_checker #(
    parameter int TRACK_BITS = 16,
    parameter int ID_BITS    = 4,
    parameter int S_DATA_W   = 24,
    parameter int M_DATA_W   = 32
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);
    import cdrs_pkg::*;

    localparam int GV_POS   = STATUS_W;
    localparam int GREQ_POS = STATUS_W + 1;
    localparam int GTRK_POS = GREQ_POS + ID_BITS;
    localparam int BUSY_POS = GTRK_POS + TRACK_BITS;

    logic                  s_fire;
    logic [STATUS_W-1:0]   m_status;
    logic                  m_gv;
    logic [ID_BITS-1:0]    m_greq;
    logic [TRACK_BITS-1:0] m_gtrk;
    logic                  m_busy;
    logic                  s_cmd_nz;

    assign s_fire   = s_tvalid && s_tready;
    assign s_cmd_nz = |s_tdata;
    assign m_status = m_tdata[STATUS_W-1:0];
    assign m_gv     = m_tdata[GV_POS];
    assign m_greq   = m_tdata[GREQ_POS +: ID_BITS];
    assign m_gtrk   = m_tdata[GTRK_POS +: TRACK_BITS];
    assign m_busy   = m_tdata[BUSY_POS];

    // A stalled result holds its contents.
    `CDRS_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // The scheduler works on one request at a time.
    `CDRS_ASSERT_NEXT(a_one_in_flight, s_fire || (s_cmd_nz && s_fire), !s_tready, "request taken while busy")

    // Grant fields are zero unless the disk is handed to someone.
    `CDRS_ASSERT_SAME(a_no_grant_zero, m_tvalid && !m_gv, (m_greq == '0) && (m_gtrk == '0), "grant fields set without a grant")

    // A grant comes with a granting status and leaves the disk busy.
    `CDRS_ASSERT_SAME(a_grant_status, m_tvalid && m_gv, m_busy && ((m_status == STATUS_GRANTED) || (m_status == STATUS_HANDED)), "grant with wrong status or idle disk")

    // Going idle reports a free disk, and the status code is always defined.
    `CDRS_ASSERT_SAME(a_status_code, m_tvalid, (m_status <= STATUS_NOTFOUND) && ((m_status != STATUS_IDLE) || !m_busy), "bad status or busy after going idle")

endmodule

bind cscan_disk_request_scheduler_core cdrs_checker #(
    .TRACK_BITS (TRACK_BITS),
    .ID_BITS    (ID_BITS),
    .S_DATA_W   (S_DATA_W),
    .M_DATA_W   (M_DATA_W)
) u_cdrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C-SCAN disk request scheduler testbench
// Streams request, release, cancel and unused-code requests into the
// scheduler while both sides of the bus idle at random. A mirror of the
// waiter table and head predicts each result, and every result that comes
// back is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import cdrs_pkg::*;

    localparam int MAX_WAITERS = 16;
    localparam int TRACK_BITS  = 16;
    localparam int ID_BITS     = 4;
    localparam int S_DATA_W    = ((CMD_W + ID_BITS + TRACK_BITS + 7) / 8) * 8;
    localparam int M_DATA_W    = ((STATUS_W + 2 + ID_BITS + TRACK_BITS + 7) / 8) * 8;

    // Code 3 has no meaning to the scheduler; it must answer "not found".
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 1000;
    localparam int DRAIN_CYCLES    = MAX_WAITERS + 3 + 20;
    localparam int STALL_LIMIT     = 5000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic                  grant_valid;
        logic [ID_BITS-1:0]    grant_requester;
        logic [TRACK_BITS-1:0] grant_track;
        logic                  disk_busy;
    } outcome_t;

    // Mirror of the scheduler state. It predicts the outcome of every accepted
    // request and holds the predictions until their results arrive.
    class cscan_mirror;
        bit                  waiter_live  [MAX_WAITERS];
        bit [ID_BITS-1:0]    waiter_id    [MAX_WAITERS];
        bit [TRACK_BITS-1:0] waiter_track [MAX_WAITERS];
        bit                  waiter_side  [MAX_WAITERS];
        int                  waiter_age   [MAX_WAITERS];
        bit                  ahead_side;
        bit [TRACK_BITS-1:0] head_pos;
        bit                  disk_owned;
        outcome_t            pending_outcomes [$];
        int                  mismatch_count;

        // Lowest track on a side; among equal tracks the oldest waiter wins.
        function int lowest_on(bit side);
            int best;
            best = -1;
            for (int i = 0; i < MAX_WAITERS; i++) begin
                if (waiter_live[i] && waiter_side[i] == side) begin
                    if (best < 0 || waiter_track[i] < waiter_track[best] ||
                        (waiter_track[i] == waiter_track[best] &&
                         waiter_age[i] > waiter_age[best]))
                        best = i;
                end
            end
            return best;
        endfunction

        function void note_request(logic [S_DATA_W-1:0] word);
            logic [CMD_W-1:0]      cmd;
            logic [ID_BITS-1:0]    id;
            logic [TRACK_BITS-1:0] trk;
            outcome_t              res;
            int                    slot;
            int                    pick;
            bit                    hit;
            cmd = word[CMD_W-1:0];
            id  = word[CMD_W +: ID_BITS];
            trk = word[CMD_W + ID_BITS +: TRACK_BITS];
            res = '0;
            res.status = STATUS_NOTFOUND;
            case (cmd)
                CMD_REQUEST: begin
                    if (!disk_owned) begin
                        disk_owned = 1'b1;
                        head_pos = trk;
                        res.status = STATUS_GRANTED;
                        res.grant_valid = 1'b1;
                        res.grant_requester = id;
                        res.grant_track = trk;
                    end else begin
                        slot = -1;
                        for (int i = 0; i < MAX_WAITERS; i++)
                            if (!waiter_live[i] && slot < 0)
                                slot = i;
                        if (slot < 0) begin
                            res.status = STATUS_FULL;
                        end else begin
                            for (int i = 0; i < MAX_WAITERS; i++)
                                if (waiter_live[i] && waiter_age[i] < MAX_WAITERS - 1)
                                    waiter_age[i]++;
                            waiter_live[slot]  = 1'b1;
                            waiter_id[slot]    = id;
                            waiter_track[slot] = trk;
                            waiter_side[slot]  = (trk >= head_pos) ? ahead_side : !ahead_side;
                            waiter_age[slot]   = 0;
                            res.status = STATUS_QUEUED;
                        end
                    end
                end
                CMD_RELEASE: begin
                    pick = lowest_on(ahead_side);
                    if (pick < 0) begin
                        pick = lowest_on(!ahead_side);
                        if (pick >= 0)
                            ahead_side = !ahead_side;
                    end
                    if (pick >= 0) begin
                        waiter_live[pick] = 1'b0;
                        head_pos = waiter_track[pick];
                        disk_owned = 1'b1;
                        res.status = STATUS_HANDED;
                        res.grant_valid = 1'b1;
                        res.grant_requester = waiter_id[pick];
                        res.grant_track = waiter_track[pick];
                    end else begin
                        disk_owned = 1'b0;
                        res.status = STATUS_IDLE;
                    end
                end
                CMD_CANCEL: begin
                    hit = 1'b0;
                    for (int i = 0; i < MAX_WAITERS; i++) begin
                        if (waiter_live[i] && waiter_id[i] == id) begin
                            waiter_live[i] = 1'b0;
                            hit = 1'b1;
                        end
                    end
                    res.status = hit ? STATUS_CANCELLED : STATUS_NOTFOUND;
                end
                default: ;
            endcase
            res.disk_busy = disk_owned;
            pending_outcomes.push_back(res);
        endfunction

        function void report(string what, outcome_t want, outcome_t seen);
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("%s: expected st=%0d gv=%0d id=%0d trk=%h busy=%0d, got st=%0d gv=%0d id=%0d trk=%h busy=%0d",
                         what, want.status, want.grant_valid, want.grant_requester,
                         want.grant_track, want.disk_busy, seen.status, seen.grant_valid,
                         seen.grant_requester, seen.grant_track, seen.disk_busy);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] word);
            outcome_t seen;
            outcome_t want;
            seen.status          = word[STATUS_W-1:0];
            seen.grant_valid     = word[STATUS_W];
            seen.grant_requester = word[STATUS_W + 1 +: ID_BITS];
            seen.grant_track     = word[STATUS_W + 1 + ID_BITS +: TRACK_BITS];
            seen.disk_busy       = word[STATUS_W + 1 + ID_BITS + TRACK_BITS];
            if (pending_outcomes.size() == 0) begin
                report("result with no request pending", '0, seen);
            end else begin
                want = pending_outcomes.pop_front();
                if (seen.status !== want.status || seen.grant_valid !== want.grant_valid ||
                    seen.grant_requester !== want.grant_requester ||
                    seen.grant_track !== want.grant_track || seen.disk_busy !== want.disk_busy)
                    report("result mismatch", want, seen);
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // cmd, requester, track (from bit 0 up)
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // status, grant_valid, grant_requester,
                                    // grant_track, disk_busy (from bit 0 up)

    cscan_mirror mirror = new;

    // Percent of cycles in which each side holds off; changed per phase.
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    cscan_disk_request_scheduler_core #(
        .MAX_WAITERS (MAX_WAITERS),
        .TRACK_BITS  (TRACK_BITS),
        .ID_BITS     (ID_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // The result side stalls at random; it is driven at the falling edge so
    // the scheduler sees a settled value at the next rising edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Both channels are observed at the rising edge. Values read here are the
    // ones from before the edge, so an accepted request and a result seen at
    // the same edge are handled in a fixed order. The watchdog ends the run
    // when neither channel moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                mirror.note_request(s_tdata);
            if (m_tvalid && m_tready)
                mirror.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("cscan_disk_request_scheduler_core: mismatch");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Presents one request and returns once the scheduler has taken it. The
    // valid line only drops when the sender decides to idle, so back-to-back
    // requests keep it high without a glitch.
    task automatic push_request(input logic [CMD_W-1:0] cmd, input logic [ID_BITS-1:0] id,
                                input logic [TRACK_BITS-1:0] trk);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'({trk, id, cmd});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // Tracks lean toward a few shared values so that ties on the lowest track
    // and requests landing exactly on the head happen often.
    function automatic logic [TRACK_BITS-1:0] pick_track();
        case ($urandom_range(3))
            0: return TRACK_BITS'($urandom);
            1: return TRACK_BITS'($urandom_range(7) << (TRACK_BITS - 3));
            2: return $urandom_range(1) ? {TRACK_BITS{1'b1}} : '0;
            default: return TRACK_BITS'($urandom_range(31));
        endcase
    endfunction

    initial begin
        int request_bias;
        int roll;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 16;
        recv_idle_pct = 79;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Release on an idle disk, and the unused command code.
        push_request(CMD_RELEASE, 4'd7, 16'h0000);
        push_request(CMD_UNUSED, 4'd15, 16'hFFFF);
        // Idle disk: granted at once, head moves to mid-range.
        push_request(CMD_REQUEST, 4'd1, 16'h8000);
        // Waiters ahead (top track, equal to head twice) and behind.
        push_request(CMD_REQUEST, 4'd2, 16'hFFFF);
        push_request(CMD_REQUEST, 4'd3, 16'h0000);
        push_request(CMD_REQUEST, 4'd4, 16'h8000);
        push_request(CMD_REQUEST, 4'd5, 16'h8000);
        // A second waiter with a duplicate id; one cancel must drop both.
        push_request(CMD_REQUEST, 4'd2, 16'h1234);
        push_request(CMD_CANCEL, 4'd2, 16'hFFFF);
        // Equal tracks go oldest first, then the empty ahead side swaps over.
        push_request(CMD_RELEASE, 4'd0, 16'h0000);
        push_request(CMD_RELEASE, 4'd0, 16'h0000);
        push_request(CMD_RELEASE, 4'd0, 16'h0000);
        // Fill the whole waiter table, then one more request is rejected.
        for (int i = 0; i <= MAX_WAITERS; i++)
            push_request(CMD_REQUEST, ID_BITS'(i), pick_track());

        // Random traffic in blocks with a varying request share, so the table
        // swings between empty and full and the sides swap many times.
        request_bias = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 3) begin
                send_idle_pct = 79;
                recv_idle_pct = 16;
            end
            if (n == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n % 40 == 0)
                request_bias = $urandom_range(75, 30);
            roll = $urandom_range(99);
            if (roll < request_bias)
                push_request(CMD_REQUEST, ID_BITS'($urandom), pick_track());
            else if (roll < request_bias + (100 - request_bias) * 2 / 3)
                push_request(CMD_RELEASE, ID_BITS'($urandom), TRACK_BITS'($urandom));
            else if (roll < 97)
                push_request(CMD_CANCEL, ID_BITS'($urandom), TRACK_BITS'($urandom));
            else
                push_request(CMD_UNUSED, ID_BITS'($urandom), TRACK_BITS'($urandom));
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (mirror.pending_outcomes.size() != 0)
            @(posedge aclk);
        // Any result that shows up late is still caught by the monitor.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mirror.mismatch_count == 0)
            $display("cscan_disk_request_scheduler_core: match");
        else
            $display("cscan_disk_request_scheduler_core: mismatch");
        $finish;
    end
endmodule
